>>> design/countdown_timer_table_unit_macros.svh
// assertion helpers for the countdown timer table
`ifndef COUNTDOWN_TIMER_TABLE_UNIT_MACROS_SVH
`define COUNTDOWN_TIMER_TABLE_UNIT_MACROS_SVH

// property checked only out of reset
`define CTU_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every edge, reset included
`define CTU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/ctu_pkg.sv
`timescale 1ns / 1ps

package ctu_pkg;

  localparam int unsigned MAX_TIMERS = 16;
  localparam int unsigned CNT_W      = $clog2(MAX_TIMERS + 1);
  localparam int unsigned IDX_W      = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int unsigned ID_W       = 16;
  localparam int unsigned TICKS_W    = 24;

  localparam logic [TICKS_W-1:0] EXPIRE_THRESHOLD = TICKS_W'(1);

  typedef enum logic [1:0] {
    FUNC_SET      = 2'd0,
    FUNC_KILL     = 2'd1,
    FUNC_KILL_ALL = 2'd2,
    FUNC_TICK     = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_UPDATED   = 3'd0,
    ST_ADDED     = 3'd1,
    ST_FULL      = 3'd2,
    ST_KILLED    = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_CLEARED   = 3'd5,
    ST_EXPIRED   = 3'd6,
    ST_IDLE      = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_READ   = 2'd1,
    S_EVAL   = 2'd2,
    S_FINISH = 2'd3
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;    // take a new beat
    logic eval;    // process the entry just read
    logic finish;  // emit the closing result, commit the count
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic             clear_in;    // incoming beat empties the table
    logic             empty;
    logic             last_entry;
    logic             stall;       // expiry found but no room for the held one
    logic             can_load;
    logic             clear_op;
    logic [CNT_W-1:0] count;
  } sts_t;

endpackage

>>> design/ctu_ctrl.sv
`timescale 1ns / 1ps

module ctu_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_tvalid_i,
  output logic          s_tready_o,
  input  ctu_pkg::sts_t sts_i,
  output ctu_pkg::cmd_t cmd_o
);
  import ctu_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) begin
          if (sts_i.clear_in || sts_i.empty) begin
            state_d = S_FINISH;
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        state_d = S_EVAL;
      end
      S_EVAL: begin
        if (!sts_i.stall) begin
          state_d = sts_i.last_entry ? S_FINISH : S_READ;
        end
      end
      S_FINISH: begin
        if (sts_i.can_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    s_tready_o    = 1'b0;
    cmd_o         = '0;
    case (state_q)
      S_IDLE: begin
        s_tready_o = 1'b1;
        cmd_o.load = s_tvalid_i;
      end
      S_EVAL: begin
        cmd_o.eval = !sts_i.stall;
      end
      S_FINISH: begin
        cmd_o.finish = sts_i.can_load;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

>>> design/ctu_dp.sv
`timescale 1ns / 1ps

module ctu_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ctu_pkg::cmd_t          cmd_i,
  output ctu_pkg::sts_t          sts_o,
  input  logic [39:0]            s_tdata_i,
  input  logic [1:0]             s_tuser_i,
  output logic                   m_tvalid_o,
  input  logic                   m_tready_i,
  output logic [15:0]            m_tdata_o,
  output logic [2:0]             m_tuser_o,
  output logic                   m_tlast_o
);
  import ctu_pkg::*;

  // table storage
  logic [ID_W-1:0]    id_mem  [MAX_TIMERS];
  logic [TICKS_W-1:0] rem_mem [MAX_TIMERS];
  logic [ID_W-1:0]    rd_id_q;
  logic [TICKS_W-1:0] rd_rem_q;

  // current operation
  func_e              op_func_q;
  logic [ID_W-1:0]    op_id_q;
  logic [TICKS_W-1:0] op_ticks_q;
  logic               op_clear_q;

  // walk state
  logic [IDX_W-1:0]   idx_q;
  logic [CNT_W-1:0]   keep_q;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               found_q;
  logic               pend_valid_q;
  logic [ID_W-1:0]    pend_id_q;

  // result register
  logic               out_valid_q;
  status_e            out_status_q, out_status_d;
  logic [ID_W-1:0]    out_id_q, out_id_d;
  logic               out_last_q, out_last_d;

  func_e              in_func;
  logic [ID_W-1:0]    in_id;
  logic               match, expire, keep_ent, set_found;
  logic [TICKS_W-1:0] rem_new;
  logic               can_load, push_eval, out_load;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [ID_W-1:0]    wr_id;
  logic [TICKS_W-1:0] wr_rem;

  assign in_func  = func_e'(s_tuser_i);
  assign in_id    = s_tdata_i[ID_W-1:0];
  assign can_load = !out_valid_q || m_tready_i;

  // per-entry decision
  always_comb begin
    match     = (rd_id_q == op_id_q) && !found_q;
    expire    = rd_rem_q <= EXPIRE_THRESHOLD;
    keep_ent  = 1'b1;
    set_found = 1'b0;
    rem_new   = rd_rem_q;
    case (op_func_q)
      FUNC_SET: begin
        set_found = match;
        rem_new   = match ? op_ticks_q : rd_rem_q;
      end
      FUNC_KILL: begin
        set_found = match;
        keep_ent  = !match;
      end
      FUNC_TICK: begin
        keep_ent = !expire;
        rem_new  = rd_rem_q - TICKS_W'(1);
      end
      default: begin
        keep_ent = 1'b1;
      end
    endcase
  end

  // a new expiry pushes out the one held back
  assign push_eval = cmd_i.eval && (op_func_q == FUNC_TICK) && expire && pend_valid_q;
  assign out_load  = push_eval || cmd_i.finish;

  // result to register (closing result or pushed expiry), committed count and table write
  always_comb begin
    out_status_d = ST_EXPIRED;
    out_id_d     = pend_id_q;
    out_last_d   = 1'b0;
    count_d      = keep_q;
    wr_en        = 1'b0;
    wr_addr      = keep_q[IDX_W-1:0];
    wr_id        = rd_id_q;
    wr_rem       = rem_new;
    if (cmd_i.eval) begin
      wr_en = keep_ent;
    end
    if (cmd_i.finish) begin
      out_last_d = 1'b1;
      if (op_clear_q) begin
        out_status_d = ST_CLEARED;
        out_id_d     = '0;
        count_d      = '0;
      end else begin
        case (op_func_q)
          FUNC_SET: begin
            out_id_d = op_id_q;
            if (found_q) begin
              out_status_d = ST_UPDATED;
            end else if (count_q < CNT_W'(MAX_TIMERS)) begin
              out_status_d = ST_ADDED;
              count_d      = CNT_W'(count_q + CNT_W'(1));
              wr_en        = 1'b1;
              wr_addr      = count_q[IDX_W-1:0];
              wr_id        = op_id_q;
              wr_rem       = op_ticks_q;
            end else begin
              out_status_d = ST_FULL;
            end
          end
          FUNC_KILL: begin
            out_id_d     = op_id_q;
            out_status_d = found_q ? ST_KILLED : ST_NOT_FOUND;
          end
          FUNC_TICK: begin
            out_status_d = pend_valid_q ? ST_EXPIRED : ST_IDLE;
            out_id_d     = pend_valid_q ? pend_id_q : '0;
          end
          default: begin
            out_status_d = ST_CLEARED;
            out_id_d     = '0;
            count_d      = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_id_q  <= id_mem[idx_q];
    rd_rem_q <= rem_mem[idx_q];
    if (wr_en) begin
      id_mem[wr_addr]  <= wr_id;
      rem_mem[wr_addr] <= wr_rem;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
      found_q      <= 1'b0;
      idx_q        <= '0;
      keep_q       <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.load) begin
        idx_q        <= '0;
        keep_q       <= '0;
        found_q      <= 1'b0;
        pend_valid_q <= 1'b0;
      end else if (cmd_i.eval) begin
        idx_q <= IDX_W'(idx_q + IDX_W'(1));
        if (keep_ent) begin
          keep_q <= CNT_W'(keep_q + CNT_W'(1));
        end
        if (set_found) begin
          found_q <= 1'b1;
        end
        if ((op_func_q == FUNC_TICK) && expire) begin
          pend_valid_q <= 1'b1;
        end
      end
      if (cmd_i.finish) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_func_q  <= in_func;
      op_id_q    <= in_id;
      op_ticks_q <= s_tdata_i[ID_W+TICKS_W-1:ID_W];
      op_clear_q <= sts_o.clear_in;
    end
    if (cmd_i.eval && (op_func_q == FUNC_TICK) && expire) begin
      pend_id_q <= rd_id_q;
    end
    if (out_load) begin
      out_status_q <= out_status_d;
      out_id_q     <= out_id_d;
      out_last_q   <= out_last_d;
    end
  end

  always_comb begin
    sts_o.clear_in   = (in_func == FUNC_KILL_ALL) || ((in_func == FUNC_KILL) && (in_id == '0));
    sts_o.empty      = (count_q == '0);
    sts_o.last_entry = (CNT_W'(CNT_W'(idx_q) + CNT_W'(1)) == count_q);
    sts_o.stall      = (op_func_q == FUNC_TICK) && expire && pend_valid_q && !can_load;
    sts_o.can_load   = can_load;
    sts_o.clear_op   = op_clear_q;
    sts_o.count      = count_q;
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_id_q;
  assign m_tuser_o  = out_status_q;
  assign m_tlast_o  = out_last_q;

endmodule

>>> design/countdown_timer_table_unit.sv
`timescale 1ns / 1ps
// countdown timer table: ordered list of up to MAX_TIMERS timers keyed by id
// input channel s_*: one beat is one operation (set, kill, kill all, tick)
//   tuser carries the operation code, tdata the id and the tick count
// output channel m_*: status in tuser, affected or expired id in tdata,
//   tlast on the final result of an operation
// set, kill and kill all give one result; a tick gives one result per
//   expired entry in table order, or a single tick idle result
// walk: each entry of the table goes through a read state (address, then the
//   registered read of the table) and an eval state, after an accept state and
//   before a closing state; kill all or an empty table go from accept straight
//   to closing
// the next beat is taken as soon as the closing result is in the output
//   register, even while that result still waits to be taken
// reset empties the table at once; entry contents stay as they were
// a stalled receiver holds the output register; the walk waits only when a
//   tick has a new expiry and the previous one cannot be passed on yet

`include "countdown_timer_table_unit_macros.svh"

module countdown_timer_table_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [39:0] s_tdata_i,   // [15:0] timer_id, [39:16] ticks
  input  logic [1:0]  s_tuser_i,   // [1:0] func
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [15:0] m_tdata_o,   // [15:0] expired_id
  output logic [2:0]  m_tuser_o,   // [2:0] status
  output logic        m_tlast_o    // last
);
  import ctu_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: accept, walk, close
  ctu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // table storage, walk counters and output register
  ctu_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o),
    .m_tlast_o  (m_tlast_o)
  );

  // checks
  `CTU_ASSERT_ALWAYS(a_cmd_onehot, clk_i, $onehot0({cmd.load, cmd.eval, cmd.finish}), "cmd overlap")
  `CTU_ASSERT(a_count_bound, clk_i, rst_ni, sts.count <= CNT_W'(MAX_TIMERS), "count overflow")
  `CTU_ASSERT(a_clear_empties, clk_i, rst_ni, cmd.finish && sts.clear_op |=> sts.empty, "clear left entries")
  `CTU_ASSERT(a_finish_drives_out, clk_i, rst_ni, cmd.finish |=> m_tvalid_o && m_tlast_o, "closing beat missing")

endmodule

>>> tb/tb_countdown_timer_table_unit.sv
`timescale 1ns / 1ps

module tb_countdown_timer_table_unit;
  import ctu_pkg::*;

  // one result beat as the checker sees it
  typedef struct {
    status_e     status;
    logic [15:0] timer_id;
    logic        last;
  } timer_result_t;

  // one row of the directed script; typed rows carry their own single result
  typedef struct {
    func_e       func;
    logic [15:0] timer_id;
    logic [23:0] ticks;
    bit          typed;
    status_e     want_status;
    logic [15:0] want_id;
  } script_row_t;

  localparam int unsigned ID_POOL_SIZE = 20;
  localparam int unsigned N_RANDOM     = 120;
  localparam int unsigned N_QUIET      = 30;
  localparam int unsigned DRAIN_CYCLES = 50;

  logic        clk_i;
  logic        rst_ni     = 1'b0;
  logic        s_tvalid_i = 1'b0;
  logic        s_tready_o;
  logic [39:0] s_tdata_i  = '0;  // [15:0] timer_id, [39:16] ticks
  logic [1:0]  s_tuser_i  = '0;  // [1:0] func
  logic        m_tvalid_o;
  logic        m_tready_i = 1'b0;
  logic [15:0] m_tdata_o;        // [15:0] expired_id
  logic [2:0]  m_tuser_o;        // [2:0] status
  logic        m_tlast_o;

  countdown_timer_table_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o),
    .m_tlast_o  (m_tlast_o)
  );

  // shadow copy of the timer table
  logic [15:0]  shadow_id   [MAX_TIMERS];
  logic [23:0]  shadow_left [MAX_TIMERS];
  int unsigned  shadow_count;

  timer_result_t new_results[$];    // results of the op just accepted
  timer_result_t awaited_results[$];

  bit          quiet_phase = 1'b0;
  int unsigned mismatches  = 0;
  int unsigned n_beats     = 0;
  int unsigned n_results   = 0;
  int unsigned n_expiries  = 0;
  int unsigned n_full      = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // apply one op to the shadow table, collect its results in new_results
  function automatic void apply_timer_op(input func_e f, input logic [15:0] id,
                                         input logic [23:0] tk);
    timer_result_t r;
    int unsigned   i;
    int unsigned   keep;
    bit            hit;
    hit = 1'b0;
    r.last = 1'b1;
    r.timer_id = id;
    case (f)
      FUNC_SET: begin
        for (i = 0; i < shadow_count && !hit; i++) begin
          if (shadow_id[i] == id) begin
            shadow_left[i] = tk;
            hit = 1'b1;
          end
        end
        if (hit) begin
          r.status = ST_UPDATED;
        end else if (shadow_count < MAX_TIMERS) begin
          shadow_id[shadow_count]   = id;
          shadow_left[shadow_count] = tk;
          shadow_count++;
          r.status = ST_ADDED;
        end else begin
          r.status = ST_FULL;
        end
        new_results.push_back(r);
      end
      FUNC_KILL, FUNC_KILL_ALL: begin
        if (f == FUNC_KILL_ALL || id == 16'h0000) begin
          shadow_count = 0;
          r.status = ST_CLEARED;
          r.timer_id = 16'h0000;
        end else begin
          // close the gap behind the first matching entry
          for (i = 0; i < shadow_count; i++) begin
            if (hit) begin
              shadow_id[i-1]   = shadow_id[i];
              shadow_left[i-1] = shadow_left[i];
            end else if (shadow_id[i] == id) begin
              hit = 1'b1;
            end
          end
          if (hit) shadow_count--;
          r.status = hit ? ST_KILLED : ST_NOT_FOUND;
        end
        new_results.push_back(r);
      end
      default: begin
        keep = 0;
        r.status = ST_EXPIRED;
        r.last = 1'b0;
        for (i = 0; i < shadow_count; i++) begin
          if (shadow_left[i] <= EXPIRE_THRESHOLD) begin
            r.timer_id = shadow_id[i];
            new_results.push_back(r);
          end else begin
            shadow_id[keep]   = shadow_id[i];
            shadow_left[keep] = shadow_left[i] - 24'd1;
            keep++;
          end
        end
        shadow_count = keep;
        if (new_results.size() == 0) begin
          r.status = ST_IDLE;
          r.timer_id = 16'h0000;
          r.last = 1'b1;
          new_results.push_back(r);
        end else begin
          new_results[new_results.size()-1].last = 1'b1;
        end
      end
    endcase
  endfunction

  // present one op, wait for the handshake, then queue what it should give
  task automatic issue_op(input func_e f, input logic [15:0] id, input logic [23:0] tk,
                          input bit typed, input status_e st, input logic [15:0] xid);
    timer_result_t r;
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      s_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= {tk, id};
    s_tuser_i  <= f;
    do @(posedge clk_i); while (s_tready_o !== 1'b1);
    n_beats++;
    new_results.delete();
    apply_timer_op(f, id, tk);
    if (typed) begin
      r.status = st;
      r.timer_id = xid;
      r.last = 1'b1;
      awaited_results.push_back(r);
    end else begin
      foreach (new_results[k]) awaited_results.push_back(new_results[k]);
    end
    foreach (new_results[k]) begin
      if (new_results[k].status == ST_EXPIRED) n_expiries++;
      if (new_results[k].status == ST_FULL) n_full++;
    end
  endtask

  function automatic script_row_t mk_row(input func_e f, input logic [15:0] id,
                                         input logic [23:0] tk, input bit typed,
                                         input status_e st, input logic [15:0] xid);
    script_row_t row;
    row.func = f;
    row.timer_id = id;
    row.ticks = tk;
    row.typed = typed;
    row.want_status = st;
    row.want_id = xid;
    return row;
  endfunction

  // result checker
  timer_result_t got_head;
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid_o === 1'b1 && m_tready_i === 1'b1) begin
      n_results++;
      if (awaited_results.size() == 0) begin
        $error("result with nothing awaited: status %0d id %h last %0d",
               m_tuser_o, m_tdata_o, m_tlast_o);
        mismatches++;
      end else begin
        got_head = awaited_results.pop_front();
        if (m_tuser_o !== got_head.status) begin
          $error("status: expected %0d, got %0d", got_head.status, m_tuser_o);
          mismatches++;
        end
        if (m_tdata_o !== got_head.timer_id) begin
          $error("expired_id: expected %h, got %h", got_head.timer_id, m_tdata_o);
          mismatches++;
        end
        if (m_tlast_o !== got_head.last) begin
          $error("last: expected %0d, got %0d", got_head.last, m_tlast_o);
          mismatches++;
        end
      end
    end
  end

  // receiver: ready stretches broken by stall bursts, none in the quiet phase
  initial begin
    @(posedge clk_i);
    forever begin
      m_tready_i <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
      if (!quiet_phase && $urandom_range(0, 1) == 0) begin
        m_tready_i <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results still awaited", awaited_results.size());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    script_row_t script[$];
    logic [15:0] id_pool [ID_POOL_SIZE];
    func_e       f;
    logic [15:0] id;
    logic [23:0] tk;
    int unsigned pick;
    int unsigned set_pct;

    // directed script
    script.push_back(mk_row(FUNC_TICK, 16'h5A5A, 24'hA5A5A5, 1'b1, ST_IDLE, 16'h0000));
    script.push_back(mk_row(FUNC_KILL, 16'h1234, 24'h0, 1'b1, ST_NOT_FOUND, 16'h1234));
    script.push_back(mk_row(FUNC_SET, 16'h0000, 24'h0, 1'b1, ST_ADDED, 16'h0000));
    script.push_back(mk_row(FUNC_SET, 16'hFFFF, 24'hFFFFFF, 1'b1, ST_ADDED, 16'hFFFF));
    script.push_back(mk_row(FUNC_SET, 16'hFFFF, 24'd2, 1'b1, ST_UPDATED, 16'hFFFF));
    // zero-tick entry expires here, the other drops to one
    script.push_back(mk_row(FUNC_TICK, 16'h0, 24'h0, 1'b0, ST_IDLE, 16'h0));
    script.push_back(mk_row(FUNC_KILL, 16'hFFFF, 24'hFFFFFF, 1'b1, ST_KILLED, 16'hFFFF));
    // fill the table, some entries due at the next tick
    for (int k = 0; k < MAX_TIMERS; k++) begin
      script.push_back(mk_row(FUNC_SET, 16'h0100 + 16'(k), 24'(k % 3), 1'b1, ST_ADDED,
                              16'h0100 + 16'(k)));
    end
    script.push_back(mk_row(FUNC_SET, 16'hBEEF, 24'd7, 1'b1, ST_FULL, 16'hBEEF));
    script.push_back(mk_row(FUNC_TICK, 16'h0, 24'h0, 1'b0, ST_IDLE, 16'h0));
    script.push_back(mk_row(FUNC_KILL_ALL, 16'hFFFF, 24'hFFFFFF, 1'b1, ST_CLEARED, 16'h0000));
    script.push_back(mk_row(FUNC_KILL, 16'h0000, 24'h0, 1'b1, ST_CLEARED, 16'h0000));

    id_pool[0] = 16'h0000;
    for (int k = 1; k < ID_POOL_SIZE; k++) id_pool[k] = 16'($urandom);

    shadow_count = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[r]) begin
      issue_op(script[r].func, script[r].timer_id, script[r].ticks, script[r].typed,
               script[r].want_status, script[r].want_id);
    end

    // random ops: ids mostly from a small pool so updates and kills hit
    for (int n = 0; n < N_RANDOM; n++) begin
      quiet_phase = (n >= N_RANDOM - N_QUIET);
      // alternate fill-heavy and drain-heavy stretches
      set_pct = ((n / 25) % 2 == 1) ? 70 : 35;
      id = ($urandom_range(0, 99) < 85) ? id_pool[$urandom_range(0, ID_POOL_SIZE - 1)]
                                        : 16'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 70) tk = 24'($urandom_range(0, 5));
      else if (pick < 90) tk = 24'($urandom_range(6, 40));
      else tk = 24'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < set_pct) begin
        f = FUNC_SET;
      end else if (pick < set_pct + (100 - set_pct) * 6 / 10) begin
        f = FUNC_TICK;
        id = 16'($urandom);
        tk = 24'($urandom);
      end else if (pick < 96) begin
        f = FUNC_KILL;
      end else begin
        f = FUNC_KILL_ALL;
        id = 16'($urandom);
        tk = 24'($urandom);
      end
      issue_op(f, id, tk, 1'b0, ST_IDLE, 16'h0000);
    end
    s_tvalid_i <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("ran %0d ops (set, kill, kill all, tick) and checked %0d results", n_beats,
             n_results);
    $display("of these %0d were expiries and %0d were sets refused on a full table",
             n_expiries, n_full);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/ctu_pkg.sv
design/ctu_ctrl.sv
design/ctu_dp.sv
design/countdown_timer_table_unit.sv
tb/tb_countdown_timer_table_unit.sv
